[hdl/lca_pkg.sv]
// Shared constants and types for the binary-lifting common ancestor engine.
// Used by tree_lca_binary_lifting; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package lca_pkg;

   localparam int MAX_NODES = 1024;
   localparam int LEVELS    = 10;

   localparam int NODE_W  = $clog2(MAX_NODES);
   localparam int LVL_W   = $clog2(LEVELS);
   localparam int DEPTH_W = LEVELS;
   localparam int JT_AW   = NODE_W + LVL_W;

   localparam logic [DEPTH_W-1:0] MAX_DEPTH = {DEPTH_W{1'b1}};

   localparam int REQ_TDATA_W = ((2 * NODE_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((NODE_W + 7) / 8) * 8;

   typedef enum logic {
      CMD_ADD   = 1'b0,
      CMD_QUERY = 1'b1
   } cmd_type;

endpackage : lca_pkg

`default_nettype wire

[hdl/tree_lca_binary_lifting.sv]
// Lowest common ancestor engine over a parent-first tree, built on binary lifting.
// Holds the depth store, the jump table and the sequencer; uses lca_pkg.
`timescale 1ns / 1ps
`default_nettype none

// After reset the block runs a clearing pass over all MAX_NODES (1024) entries of
// the depth store, with req_tready low. An add item (tuser 0) makes one depth read,
// then writes the new node's jump-table entries, one per cycle; an ignored add
// goes back to idle after the check. A query item (tuser 1) runs on the jump table's
// registered read ports: the lift phase walks the depth-difference bits from the
// lowest up to the highest set bit, with a table read and write-back for each set
// bit; then come the compare, the joint descent (a read and a write-back per level,
// from the top level down), the final parent read and the result step. A query in
// which one node is the other's ancestor skips the descent and the parent read.
// Invalid queries go from the check straight to the result step. A result waits
// there while the output register is full. Only one item is in work at a time; a
// finished result waits in the output register while the next item is taken.
module tree_lca_binary_lifting
   import lca_pkg::*;
(
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_tvalid,
   output logic                        req_tready,
   input  wire  [REQ_TDATA_W-1:0]      req_tdata,  // node_a, node_b, zero fill
   input  wire                         req_tuser,  // command
   output logic                        rsp_tvalid,
   input  wire                         rsp_tready,
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,  // ancestor, zero fill
   output logic                        rsp_tuser   // bad_query
);

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_CHECK,
      S_FILL,
      S_LIFT_RD,
      S_LIFT_WB,
      S_CMP,
      S_DESC_RD,
      S_DESC_WB,
      S_FINAL_RD,
      S_FINAL_WB,
      S_RESULT
   } state_type;

   state_type          state_ff, state_in;
   cmd_type            cmd_ff, cmd_in;
   logic [NODE_W-1:0]  a_ff, a_in;
   logic [NODE_W-1:0]  b_ff, b_in;
   logic [DEPTH_W-1:0] diff_ff, diff_in;
   logic [LVL_W-1:0]   lvl_ff, lvl_in;
   logic               cur_zero_ff, cur_zero_in;
   logic [NODE_W-1:0]  clr_ff, clr_in;
   logic [NODE_W-1:0]  res_anc_ff, res_anc_in;
   logic               res_bad_ff, res_bad_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [NODE_W-1:0]  rsp_anc_ff, rsp_anc_in;
   logic               rsp_bad_ff, rsp_bad_in;

   logic [DEPTH_W-1:0] depth_mem [MAX_NODES];
   logic [DEPTH_W-1:0] depth_qa_ff;
   logic [DEPTH_W-1:0] depth_qb_ff;
   logic               dep_re;
   logic               dep_we;
   logic [NODE_W-1:0]  dep_wa;
   logic [DEPTH_W-1:0] dep_wd;

   logic [NODE_W-1:0]  jump_mem [2**JT_AW];
   logic [NODE_W-1:0]  jt_q1_ff;
   logic [NODE_W-1:0]  jt_q2_ff;
   logic               jt_re1;
   logic               jt_re2;
   logic [JT_AW-1:0]   jt_ra1;
   logic [JT_AW-1:0]   jt_ra2;
   logic               jt_we;
   logic [JT_AW-1:0]   jt_wa;
   logic [NODE_W-1:0]  jt_wd;

   logic [NODE_W-1:0]  req_a;
   logic [NODE_W-1:0]  req_b;
   logic               req_fire;
   logic [NODE_W-1:0]  fill_val;
   logic               add_ok;
   logic               query_bad;

   assign req_a      = req_tdata[NODE_W-1:0];
   assign req_b      = req_tdata[2*NODE_W-1:NODE_W];
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(rsp_anc_ff);
   assign rsp_tuser  = rsp_bad_ff;

   assign fill_val  = cur_zero_ff ? '0 : jt_q1_ff;
   assign add_ok    = (a_ff != '0) && (depth_qa_ff == '0)
                      && ((b_ff == '0) || (depth_qb_ff != '0))
                      && (depth_qb_ff != MAX_DEPTH);
   assign query_bad = (a_ff == '0) || (b_ff == '0)
                      || (depth_qa_ff == '0) || (depth_qb_ff == '0);

   always_ff @(posedge clock) begin
      if (dep_we) begin
         depth_mem[dep_wa] <= dep_wd;
      end
      if (dep_re) begin
         depth_qa_ff <= depth_mem[req_a];
         depth_qb_ff <= depth_mem[req_b];
      end
   end

   always_ff @(posedge clock) begin
      if (jt_we) begin
         jump_mem[jt_wa] <= jt_wd;
      end
      if (jt_re1) begin
         jt_q1_ff <= jump_mem[jt_ra1];
      end
      if (jt_re2) begin
         jt_q2_ff <= jump_mem[jt_ra2];
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      diff_in      = diff_ff;
      lvl_in       = lvl_ff;
      cur_zero_in  = cur_zero_ff;
      clr_in       = clr_ff;
      res_anc_in   = res_anc_ff;
      res_bad_in   = res_bad_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_anc_in   = rsp_anc_ff;
      rsp_bad_in   = rsp_bad_ff;
      dep_re       = 1'b0;
      dep_we       = 1'b0;
      dep_wa       = a_ff;
      dep_wd       = '0;
      jt_re1       = 1'b0;
      jt_re2       = 1'b0;
      jt_ra1       = {a_ff, lvl_ff};
      jt_ra2       = {b_ff, lvl_ff};
      jt_we        = 1'b0;
      jt_wa        = {a_ff, lvl_ff};
      jt_wd        = fill_val;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            dep_we = 1'b1;
            dep_wa = clr_ff;
            clr_in = NODE_W'(clr_ff + 1'b1);
            if (clr_ff == NODE_W'(MAX_NODES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               dep_re   = 1'b1;
               cmd_in   = cmd_type'(req_tuser);
               a_in     = req_a;
               b_in     = req_b;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (cmd_ff == CMD_ADD) begin
               if (add_ok) begin
                  dep_we      = 1'b1;
                  dep_wd      = DEPTH_W'(depth_qb_ff + 1'b1);
                  jt_we       = 1'b1;
                  jt_wa       = {a_ff, LVL_W'(0)};
                  jt_wd       = b_ff;
                  jt_re1      = 1'b1;
                  jt_ra1      = {b_ff, LVL_W'(0)};
                  cur_zero_in = (b_ff == '0);
                  lvl_in      = LVL_W'(1);
                  state_in    = S_FILL;
               end else begin
                  state_in = S_IDLE;
               end
            end else if (query_bad) begin
               res_anc_in = '0;
               res_bad_in = 1'b1;
               state_in   = S_RESULT;
            end else begin
               if (depth_qa_ff < depth_qb_ff) begin
                  a_in    = b_ff;
                  b_in    = a_ff;
                  diff_in = DEPTH_W'(depth_qb_ff - depth_qa_ff);
               end else begin
                  diff_in = DEPTH_W'(depth_qa_ff - depth_qb_ff);
               end
               lvl_in   = '0;
               state_in = S_LIFT_RD;
            end
         end
         S_FILL: begin
            jt_we       = 1'b1;
            jt_re1      = 1'b1;
            jt_ra1      = {fill_val, lvl_ff};
            cur_zero_in = (fill_val == '0);
            if (lvl_ff == LVL_W'(LEVELS - 1)) begin
               state_in = S_IDLE;
            end else begin
               lvl_in = LVL_W'(lvl_ff + 1'b1);
            end
         end
         S_LIFT_RD: begin
            if (diff_ff == '0) begin
               state_in = S_CMP;
            end else if (diff_ff[0]) begin
               jt_re1   = 1'b1;
               state_in = S_LIFT_WB;
            end else begin
               diff_in = diff_ff >> 1;
               lvl_in  = LVL_W'(lvl_ff + 1'b1);
            end
         end
         S_LIFT_WB: begin
            a_in     = jt_q1_ff;
            diff_in  = diff_ff >> 1;
            lvl_in   = LVL_W'(lvl_ff + 1'b1);
            state_in = S_LIFT_RD;
         end
         S_CMP: begin
            if (a_ff == b_ff) begin
               res_anc_in = a_ff;
               res_bad_in = 1'b0;
               state_in   = S_RESULT;
            end else begin
               lvl_in   = LVL_W'(LEVELS - 1);
               state_in = S_DESC_RD;
            end
         end
         S_DESC_RD: begin
            jt_re1   = 1'b1;
            jt_re2   = 1'b1;
            state_in = S_DESC_WB;
         end
         S_DESC_WB: begin
            if (jt_q1_ff != jt_q2_ff) begin
               a_in = jt_q1_ff;
               b_in = jt_q2_ff;
            end
            if (lvl_ff == '0) begin
               state_in = S_FINAL_RD;
            end else begin
               lvl_in   = LVL_W'(lvl_ff - 1'b1);
               state_in = S_DESC_RD;
            end
         end
         S_FINAL_RD: begin
            jt_re1   = 1'b1;
            jt_ra1   = {a_ff, LVL_W'(0)};
            state_in = S_FINAL_WB;
         end
         S_FINAL_WB: begin
            res_anc_in = jt_q1_ff;
            res_bad_in = 1'b0;
            state_in   = S_RESULT;
         end
         S_RESULT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_anc_in   = res_anc_ff;
               rsp_bad_in   = res_bad_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      diff_ff     <= diff_in;
      lvl_ff      <= lvl_in;
      cur_zero_ff <= cur_zero_in;
      res_anc_ff  <= res_anc_in;
      res_bad_ff  <= res_bad_in;
      rsp_anc_ff  <= rsp_anc_in;
      rsp_bad_ff  <= rsp_bad_in;
   end

`ifndef ASSERT_OFF
   a_rsp_from_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_RESULT))
      else $error("result shown without a finished query");

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_bad_ff) |-> (rsp_anc_ff == '0))
      else $error("bad query carries a nonzero ancestor");

   a_no_row0_write: assert property (@(posedge clock) disable iff (reset)
      jt_we |-> (jt_wa[JT_AW-1:LVL_W] != '0))
      else $error("jump table write into the root row");

   a_add_depth: assert property (@(posedge clock) disable iff (reset)
      (dep_we && (state_ff == S_CHECK)) |-> (dep_wd != '0))
      else $error("added node recorded at depth zero");

   a_desc_distinct: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DESC_RD) |-> ((a_ff != b_ff) && (a_ff != '0)))
      else $error("descent on equal or root nodes");
`endif

endmodule : tree_lca_binary_lifting

`default_nettype wire

[bench/tb_top.sv]
// Self-checking bench for tree_lca_binary_lifting: parent-first adds and ancestor queries.
// Drives the request stream, predicts each answer and checks it; uses lca_pkg.
`timescale 1ns / 1ps

module tb_top;
   import lca_pkg::*;

   localparam int RUN_LIMIT    = 300000;
   localparam int TAIL_CYCLES  = 100;
   localparam int RANDOM_ITEMS = 490;

   typedef struct {
      cmd_type           cmd;
      logic [NODE_W-1:0] node_a;
      logic [NODE_W-1:0] node_b;
   } tree_req_type;

   typedef struct {
      logic [NODE_W-1:0] ancestor;
      logic              bad_query;
   } ancestor_answer_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;   // node_a, node_b, zero fill
   logic                   req_tuser  = 1'b0; // command
   logic                   rsp_tready = 1'b0;
   wire                    req_tready;
   wire                    rsp_tvalid;
   wire  [RSP_TDATA_W-1:0] rsp_tdata;         // ancestor, zero fill
   wire                    rsp_tuser;         // bad_query

   // predicted tree
   logic [DEPTH_W-1:0] depth_mem [MAX_NODES];
   logic [NODE_W-1:0]  jump_mem  [MAX_NODES][LEVELS];

   // stimulus-side view of which nodes exist
   bit                 planned [MAX_NODES];
   int                 tree_nodes [$];
   int                 newest_node;

   tree_req_type        pending_q [$];
   ancestor_answer_type answer_q [$];
   tree_req_type        next_req;
   tree_req_type        seen_req;
   ancestor_answer_type want;

   int  drv_cnt  = 0;
   int  acc_cnt  = 0;
   int  item_total;
   int  err_cnt  = 0;
   int  cyc      = 0;
   bit  calm;

   tree_lca_binary_lifting u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) cyc <= cyc + 1;

   task automatic report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      err_cnt++;
   endtask

   function automatic logic [NODE_W-1:0] hop(logic [NODE_W-1:0] n, int k);
      if (n == 0 || k >= LEVELS) return '0;
      return jump_mem[n][k];
   endfunction

   function automatic bit present(logic [NODE_W-1:0] n);
      return n != 0 && depth_mem[n] != 0;
   endfunction

   function automatic void graft_node(logic [NODE_W-1:0] n, logic [NODE_W-1:0] p);
      logic [DEPTH_W-1:0] pd;
      if (n == 0 || depth_mem[n] != 0) return;
      if (p != 0 && !present(p)) return;
      pd = (p == 0) ? '0 : depth_mem[p];
      if (pd >= MAX_DEPTH) return;
      depth_mem[n] = pd + 1'b1;
      jump_mem[n][0] = p;
      for (int k = 1; k < LEVELS; k++)
         jump_mem[n][k] = hop(jump_mem[n][k-1], k - 1);
   endfunction

   function automatic logic [NODE_W-1:0] meet_point(logic [NODE_W-1:0] a,
                                                    logic [NODE_W-1:0] b);
      logic [NODE_W-1:0]  t;
      logic [DEPTH_W-1:0] diff;
      if (depth_mem[a] < depth_mem[b]) begin
         t = a;
         a = b;
         b = t;
      end
      diff = depth_mem[a] - depth_mem[b];
      for (int k = 0; k < LEVELS; k++)
         if (diff[k]) a = hop(a, k);
      if (a == b) return a;
      for (int k = LEVELS - 1; k >= 0; k--) begin
         if (hop(a, k) != hop(b, k)) begin
            a = hop(a, k);
            b = hop(b, k);
         end
      end
      return hop(a, 0);
   endfunction

   function automatic void push_item(cmd_type cmd, int a, int b);
      tree_req_type it;
      it.cmd    = cmd;
      it.node_a = a[NODE_W-1:0];
      it.node_b = b[NODE_W-1:0];
      pending_q.insert(pending_q.size(), it);
   endfunction

   function automatic void plan_add(int n, int p);
      push_item(CMD_ADD, n, p);
      if (n != 0 && !planned[n] && (p == 0 || planned[p])) begin
         planned[n] = 1'b1;
         tree_nodes.insert(tree_nodes.size(), n);
         newest_node = n;
      end
   endfunction

   function automatic int any_tree_node();
      if (tree_nodes.size() == 0) return $urandom_range(0, MAX_NODES - 1);
      return tree_nodes[$urandom_range(0, tree_nodes.size() - 1)];
   endfunction

   // driver and receiver: change inputs at the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         calm = acc_cnt >= 300 && acc_cnt < 400;
         if (drv_cnt == acc_cnt) begin
            if (pending_q.size() != 0 && (calm || $urandom_range(0, 99) >= 16)) begin
               next_req = pending_q.pop_front();
               req_tuser  <= next_req.cmd;
               req_tdata  <= REQ_TDATA_W'({next_req.node_b, next_req.node_a});
               req_tvalid <= 1'b1;
               drv_cnt++;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= calm || ($urandom_range(0, 99) >= 16);
      end
   end

   // monitor: sample both channels at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            seen_req.cmd    = cmd_type'(req_tuser);
            seen_req.node_a = req_tdata[NODE_W-1:0];
            seen_req.node_b = req_tdata[2*NODE_W-1:NODE_W];
            if (seen_req.cmd == CMD_ADD) begin
               graft_node(seen_req.node_a, seen_req.node_b);
            end else if (!present(seen_req.node_a) || !present(seen_req.node_b)) begin
               want.ancestor  = '0;
               want.bad_query = 1'b1;
               answer_q.insert(answer_q.size(), want);
            end else begin
               want.ancestor  = meet_point(seen_req.node_a, seen_req.node_b);
               want.bad_query = 1'b0;
               answer_q.insert(answer_q.size(), want);
            end
            acc_cnt++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (answer_q.size() == 0) begin
               report_mismatch($sformatf("result ancestor=%0d bad=%0b with none pending",
                                         rsp_tdata[NODE_W-1:0], rsp_tuser));
            end else begin
               want = answer_q.pop_front();
               if (rsp_tdata[NODE_W-1:0] !== want.ancestor)
                  report_mismatch($sformatf("ancestor got %0d want %0d",
                                            rsp_tdata[NODE_W-1:0], want.ancestor));
               if (rsp_tuser !== want.bad_query)
                  report_mismatch($sformatf("bad_query got %0b want %0b",
                                            rsp_tuser, want.bad_query));
            end
         end
      end
   end

   initial begin
      int useful;
      int r;
      int s;
      int n;
      int p;
      int a;
      int b;
      bit timed_out;

      for (int i = 0; i < MAX_NODES; i++) begin
         depth_mem[i] = '0;
         planned[i]   = 1'b0;
         for (int k = 0; k < LEVELS; k++) jump_mem[i][k] = '0;
      end
      newest_node = 0;

      // directed: empty tree, ignored adds, small tree, separate subtrees, bad queries
      push_item(CMD_QUERY, 5, 6);
      plan_add(0, 0);
      plan_add(5, 7);
      plan_add(1, 0);
      plan_add(2, 1);
      plan_add(3, 1);
      plan_add(4, 2);
      push_item(CMD_QUERY, 4, 3);
      push_item(CMD_QUERY, 3, 4);
      push_item(CMD_QUERY, 4, 4);
      push_item(CMD_QUERY, 4, 1);
      plan_add(2, 3);
      push_item(CMD_QUERY, 2, 3);
      plan_add(1023, 0);
      push_item(CMD_QUERY, 4, 1023);
      push_item(CMD_QUERY, 0, 1);
      push_item(CMD_QUERY, 1, 0);
      push_item(CMD_QUERY, 0, 0);
      push_item(CMD_QUERY, 1023, 1023);
      plan_add(682, 1023);
      plan_add(341, 682);
      push_item(CMD_QUERY, 341, 4);
      push_item(CMD_QUERY, 341, 1023);
      push_item(CMD_QUERY, 512, 1);
      plan_add(6, 0);

      // random: mostly well-formed adds and queries, a deep chain early on
      useful = 0;
      while (useful < RANDOM_ITEMS) begin
         r = $urandom_range(0, 99);
         if (r < 48 && tree_nodes.size() < MAX_NODES - 8) begin
            do n = $urandom_range(1, MAX_NODES - 1); while (planned[n]);
            s = $urandom_range(0, 99);
            if (s < ((useful < 250) ? 90 : 50) && newest_node != 0)
               p = newest_node;
            else if (s < 88)
               p = any_tree_node();
            else
               p = 0;
            plan_add(n, p);
            useful++;
         end else if (r < 88) begin
            a = any_tree_node();
            s = $urandom_range(0, 99);
            if (s < 8)
               b = a;
            else if (s < 18)
               b = $urandom_range(0, MAX_NODES - 1);
            else
               b = any_tree_node();
            if ($urandom_range(0, 1)) push_item(CMD_QUERY, a, b);
            else push_item(CMD_QUERY, b, a);
            useful++;
         end else begin
            a = $urandom_range(0, MAX_NODES - 1);
            b = $urandom_range(0, MAX_NODES - 1);
            if ($urandom_range(0, 1)) begin
               push_item(CMD_QUERY, a, b);
               useful++;
            end else begin
               plan_add(a, b);
            end
         end
      end
      item_total = pending_q.size();

      repeat (9) @(negedge clock);
      reset <= 1'b0;

      while ((acc_cnt < item_total || answer_q.size() != 0) && cyc < RUN_LIMIT)
         @(posedge clock);
      timed_out = cyc >= RUN_LIMIT;
      if (!timed_out) repeat (TAIL_CYCLES) @(posedge clock);
      if (timed_out)
         $display("TIMEOUT after %0d cycles, %0d of %0d items taken", cyc, acc_cnt,
                  item_total);
      if (answer_q.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", answer_q.size()));

      if (timed_out || err_cnt != 0)
         $display("Some tests failed");
      else
         $display("All tests passed");
      $finish;
   end

endmodule : tb_top
